### design/scl_pkg.sv
package scl_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned KeyW   = 16;
  localparam int unsigned CodeW  = 16;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned SizeW  = 32;
  localparam int unsigned CodecW = 8;
  localparam int unsigned CountW = 11;
  localparam int unsigned IndexW = 10;
  localparam int unsigned EncKeyW = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  // Item actions.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ENTRY_COUNT  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_LOW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_ALPHA_HIGH   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NUM_LOW      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NUM_HIGH     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ENCRYPT_ON   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_ENCRYPT_KEY  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_BASE_ADDRESS = 3'd7;

  // Codec numbers and playback limits.
  localparam logic [CodecW-1:0] CODEC_COMPRESSED = 8'd0;
  localparam logic [CodecW-1:0] CODEC_WAV        = 8'd2;
  localparam logic [8:0]        VOICE_ALIGN_MASK = 9'h1FF;
  localparam logic [SizeW-1:0]  VOICE_MIN_SIZE   = 32'd512;
  localparam logic [EncKeyW-1:0] ENC_KEY_MAX     = 8'h07;

  typedef struct packed {
    logic [KeyW-1:0]   key;
    logic [CodeW-1:0]  code;
    logic [AddrW-1:0]  voice_address;
    logic [SizeW-1:0]  clip_bytes;
    logic [CodecW-1:0] codec;
  } record_t;

  typedef struct packed {
    logic [CountW-1:0]  entry_count;
    logic [CodeW-1:0]   alpha_low;
    logic [CodeW-1:0]   alpha_high;
    logic [CodeW-1:0]   num_low;
    logic [CodeW-1:0]   num_high;
    logic               encrypt_on;
    logic [EncKeyW-1:0] encrypt_key;
    logic [AddrW-1:0]   base_address;
  } config_t;

  typedef struct packed {
    logic              found;
    logic [CodeW-1:0]  hit_code;
    logic [CodeW-1:0]  code_class;
    logic              voice_ok;
    logic              voice_is_wav;
    logic              speech_encrypted;
    logic [AddrW-1:0]  voice_start;
  } result_t;

  typedef struct packed {
    logic idle;
    logic done;
    logic found;
  } search_status_t;

endpackage

### design/scl_mem.sv
module scl_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  scl_pkg::record_t  wr_rec,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output scl_pkg::record_t  rd_rec
);

  scl_pkg::record_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_rec;
    end
    if (rd_en) begin
      rd_rec <= mem[rd_addr];
    end
  end

endmodule

### design/scl_search.sv
module scl_search #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned AW = 10,
  parameter int unsigned CW = 11
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start_lookup,
  input  logic                         start_load,
  input  logic [scl_pkg::KeyW-1:0]     search_key,
  input  logic [scl_pkg::CountW-1:0]   entry_count,
  input  logic [scl_pkg::KeyW-1:0]     rd_key,
  input  logic                         finish_ack,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  output scl_pkg::search_status_t      status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_CMP,
    S_DONE
  } state_t;

  state_t                     state;
  logic [CW-1:0]              left;
  logic [CW-1:0]              right;
  logic [CW-1:0]              mid;
  logic [scl_pkg::KeyW-1:0]   key;
  logic                       found;

  logic [CW-1:0]  right_init;
  logic [CW:0]    start_sum;
  logic [CW-1:0]  start_mid;
  logic           key_eq;
  logic           key_gt;
  logic [CW-1:0]  left_next;
  logic [CW-1:0]  right_next;
  logic [CW:0]    next_sum;
  logic [CW-1:0]  mid_next;

  // Never search past the end of the table.
  assign right_init = ({21'd0, entry_count} > 32'(TABLE_DEPTH)) ?
                      CW'(TABLE_DEPTH) : CW'(entry_count);

  assign start_sum = {1'b0, left} + {1'b0, right};
  assign start_mid = start_sum[CW:1];

  // The shared compare unit: one probe result per cycle.
  assign key_eq     = (key == rd_key);
  assign key_gt     = (key > rd_key);
  assign left_next  = key_gt ? (mid + CW'(1)) : left;
  assign right_next = key_gt ? right : mid;
  assign next_sum   = {1'b0, left_next} + {1'b0, right_next};
  assign mid_next   = next_sum[CW:1];

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = start_mid[AW-1:0];
    if (state == S_START) begin
      rd_en = (left < right);
    end else if (state == S_CMP) begin
      rd_en   = !key_eq && (left_next < right_next);
      rd_addr = mid_next[AW-1:0];
    end
  end

  assign status.idle  = (state == S_IDLE);
  assign status.done  = (state == S_DONE);
  assign status.found = found;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          found <= 1'b0;
          left  <= '0;
          right <= right_init;
          key   <= search_key;
          if (start_lookup) begin
            state <= S_START;
          end else if (start_load) begin
            state <= S_DONE;
          end
        end
        S_START: begin
          mid <= start_mid;
          if (left < right) begin
            state <= S_CMP;
          end else begin
            state <= S_DONE;
          end
        end
        S_CMP: begin
          if (key_eq) begin
            found <= 1'b1;
            state <= S_DONE;
          end else begin
            left  <= left_next;
            right <= right_next;
            mid   <= mid_next;
            if (!(left_next < right_next)) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (finish_ack) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/scl_check.sv
module scl_check (
  input  logic              found,
  input  scl_pkg::record_t  rec,
  input  scl_pkg::config_t  cfg,
  output scl_pkg::result_t  result
);

  logic codec_ok;
  logic enc_bad;
  logic in_alpha;
  logic in_num;
  logic ok;

  assign codec_ok = (rec.codec == scl_pkg::CODEC_COMPRESSED) ||
                    (rec.codec == scl_pkg::CODEC_WAV);
  assign enc_bad  = cfg.encrypt_on && (cfg.encrypt_key > scl_pkg::ENC_KEY_MAX);
  assign in_alpha = (rec.code >= cfg.alpha_low) && (rec.code <= cfg.alpha_high);
  assign in_num   = (rec.code >= cfg.num_low) && (rec.code <= cfg.num_high);
  assign ok = (rec.voice_address != '0) &&
              ((rec.voice_address[8:0] & scl_pkg::VOICE_ALIGN_MASK) == 9'd0) &&
              (rec.clip_bytes >= scl_pkg::VOICE_MIN_SIZE) && codec_ok && !enc_bad;

  always_comb begin
    result = '0;
    if (found) begin
      result.found    = 1'b1;
      result.hit_code = rec.code;
      if (in_alpha) begin
        result.code_class = cfg.alpha_low;
      end else if (in_num) begin
        result.code_class = cfg.num_low;
      end else begin
        result.code_class = rec.code;
      end
      result.voice_ok         = ok;
      result.voice_is_wav     = (rec.codec == scl_pkg::CODEC_WAV);
      result.speech_encrypted = cfg.encrypt_on &&
                                (cfg.encrypt_key <= scl_pkg::ENC_KEY_MAX);
      result.voice_start      = rec.voice_address + cfg.base_address;
    end
  end

endmodule

### design/sorted_code_table_lookup.sv
// Channel   Direction  Handshake              Beat carries
// in        input      in_valid / in_ready    action, load record, search_key
// out       output     out_valid / out_ready  found, code, class, voice checks
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A load beat goes from the idle state to the final state and on to the output
// register. A lookup beat passes the start state, one compare state per probe
// of the binary search (at most about log2(entry_count) + 1 probes) and the
// final state; each probe is one read of the record memory and one pass through
// the key compare. Reset clears the control state and the configuration
// registers; the record memory is not cleared and holds nothing meaningful
// until loaded. The input side takes the next beat as soon as the result is in
// the output register, even while that register waits on out_ready; a stalled
// output holds the sequencer in its final state until the register frees.
module sorted_code_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              action,
  input  logic [scl_pkg::IndexW-1:0]        entry_index,
  input  logic [scl_pkg::KeyW-1:0]          entry_key,
  input  logic [scl_pkg::CodeW-1:0]         entry_code,
  input  logic [scl_pkg::AddrW-1:0]         entry_voice_address,
  input  logic [scl_pkg::SizeW-1:0]         entry_voice_size,
  input  logic [scl_pkg::CodecW-1:0]        entry_codec,
  input  logic [scl_pkg::KeyW-1:0]          search_key,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [scl_pkg::CodeW-1:0]         hit_code,
  output logic [scl_pkg::CodeW-1:0]         code_class,
  output logic                              voice_ok,
  output logic                              voice_is_wav,
  output logic                              speech_encrypted,
  output logic [scl_pkg::AddrW-1:0]         voice_start,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scl_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [scl_pkg::CfgDataW-1:0]      cfg_data
);

  // Address width of the record memory and width of the search bounds, which
  // must be able to hold TABLE_DEPTH itself.
  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  scl_pkg::config_t         cfg;
  scl_pkg::search_status_t  status;
  scl_pkg::record_t         wr_rec;
  scl_pkg::record_t         rd_rec;
  scl_pkg::result_t         result;
  scl_pkg::result_t         out_reg;

  logic           in_accept;
  logic           start_lookup;
  logic           start_load;
  logic           wr_en;
  logic [AW-1:0]  wr_addr;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           finish_ack;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        scl_pkg::REG_ENTRY_COUNT:  cfg.entry_count  <= cfg_data[scl_pkg::CountW-1:0];
        scl_pkg::REG_ALPHA_LOW:    cfg.alpha_low    <= cfg_data[scl_pkg::CodeW-1:0];
        scl_pkg::REG_ALPHA_HIGH:   cfg.alpha_high   <= cfg_data[scl_pkg::CodeW-1:0];
        scl_pkg::REG_NUM_LOW:      cfg.num_low      <= cfg_data[scl_pkg::CodeW-1:0];
        scl_pkg::REG_NUM_HIGH:     cfg.num_high     <= cfg_data[scl_pkg::CodeW-1:0];
        scl_pkg::REG_ENCRYPT_ON:   cfg.encrypt_on   <= cfg_data[0];
        scl_pkg::REG_ENCRYPT_KEY:  cfg.encrypt_key  <= cfg_data[scl_pkg::EncKeyW-1:0];
        scl_pkg::REG_BASE_ADDRESS: cfg.base_address <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A new beat is taken whenever the sequencer is idle.
  assign in_ready     = status.idle;
  assign in_accept    = in_valid && in_ready;
  assign start_lookup = in_accept && (action == scl_pkg::ACT_LOOKUP);
  assign start_load   = in_accept && (action == scl_pkg::ACT_LOAD);

  // A load beyond the table is dropped but still answers with an empty result.
  assign wr_en   = start_load && ({22'd0, entry_index} < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(entry_index);
  assign wr_rec  = '{key: entry_key, code: entry_code,
                     voice_address: entry_voice_address,
                     clip_bytes: entry_voice_size, codec: entry_codec};

  scl_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec)
  );

  scl_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_search (
    .clk          (clk),
    .rst          (rst),
    .start_lookup (start_lookup),
    .start_load   (start_load),
    .search_key   (search_key),
    .entry_count  (cfg.entry_count),
    .rd_key       (rd_rec.key),
    .finish_ack   (finish_ack),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .status       (status)
  );

  // On a hit the read register still holds the matching record, since no
  // further probe is issued after the match.
  scl_check u_check (
    .found  (status.found),
    .rec    (rd_rec),
    .cfg    (cfg),
    .result (result)
  );

  // Output register: loaded once the search is done and the slot is free.
  assign finish_ack = status.done && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_ack) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_ack) begin
      out_reg <= result;
    end
  end

  assign found            = out_reg.found;
  assign hit_code         = out_reg.hit_code;
  assign code_class       = out_reg.code_class;
  assign voice_ok         = out_reg.voice_ok;
  assign voice_is_wav     = out_reg.voice_is_wav;
  assign speech_encrypted = out_reg.speech_encrypted;
  assign voice_start      = out_reg.voice_start;

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TABLE_DEPTH = 1024;
  // Far above the slowest legal run: about thirteen hundred beats through the
  // block plus long random stalls on either side.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // The end of the run waits well past the slowest full-table lookup.
  localparam int unsigned DRAIN_CYCLES = 40;

  logic                         clk;
  logic                         rst = 1'b1;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         action = scl_pkg::ACT_LOAD;
  logic [scl_pkg::IndexW-1:0]   entry_index = '0;
  logic [scl_pkg::KeyW-1:0]     entry_key = '0;
  logic [scl_pkg::CodeW-1:0]    entry_code = '0;
  logic [scl_pkg::AddrW-1:0]    entry_voice_address = '0;
  logic [scl_pkg::SizeW-1:0]    entry_voice_size = '0;
  logic [scl_pkg::CodecW-1:0]   entry_codec = '0;
  logic [scl_pkg::KeyW-1:0]     search_key = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         found;
  logic [scl_pkg::CodeW-1:0]    hit_code;
  logic [scl_pkg::CodeW-1:0]    code_class;
  logic                         voice_ok;
  logic                         voice_is_wav;
  logic                         speech_encrypted;
  logic [scl_pkg::AddrW-1:0]    voice_start;

  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [scl_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [scl_pkg::CfgDataW-1:0] cfg_data = '0;

  sorted_code_table_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .entry_index(entry_index),
    .entry_key(entry_key),
    .entry_code(entry_code),
    .entry_voice_address(entry_voice_address),
    .entry_voice_size(entry_voice_size),
    .entry_codec(entry_codec),
    .search_key(search_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .found(found),
    .hit_code(hit_code),
    .code_class(code_class),
    .voice_ok(voice_ok),
    .voice_is_wav(voice_is_wav),
    .speech_encrypted(speech_encrypted),
    .voice_start(voice_start),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Shadow copy of the record memory and the registers. Both are updated at
  // the clock edge where the block accepts the beat, so every expectation is
  // computed from exactly the state the block sees for that beat.
  scl_pkg::record_t  record_copy [TABLE_DEPTH];
  bit                record_written [TABLE_DEPTH];
  int unsigned       written_total = 0;
  scl_pkg::config_t  cfg_copy = '0;

  // Expected results in beat order, oldest first.
  scl_pkg::result_t  pending_results [$];
  scl_pkg::result_t  oldest_expected;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  int          error_count = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The receiver drops out_ready at random; rx_idle_pct sets how often.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Binary search over the shadow table, probing in the same order as the
  // block: left starts at zero, right at the clamped entry count, and the
  // probe is the floor of their mean. An unsorted table simply yields
  // whatever this probe sequence meets, which is usually a miss.
  function automatic scl_pkg::result_t search_table(input logic [scl_pkg::KeyW-1:0] key);
    scl_pkg::result_t res;
    scl_pkg::record_t rec;
    int unsigned      left;
    int unsigned      right;
    int unsigned      mid;
    logic             enc_bad;
    res = '0;
    left = 0;
    right = 32'(cfg_copy.entry_count);
    if (right > TABLE_DEPTH) begin
      right = TABLE_DEPTH;
    end
    enc_bad = cfg_copy.encrypt_on && (cfg_copy.encrypt_key > scl_pkg::ENC_KEY_MAX);
    while (left < right) begin
      mid = (left + right) >> 1;
      rec = record_copy[mid];
      if (key == rec.key) begin
        res.found = 1'b1;
        res.hit_code = rec.code;
        // The alphabetic range wins over the numeric one when they overlap.
        if (rec.code >= cfg_copy.alpha_low && rec.code <= cfg_copy.alpha_high) begin
          res.code_class = cfg_copy.alpha_low;
        end else if (rec.code >= cfg_copy.num_low && rec.code <= cfg_copy.num_high) begin
          res.code_class = cfg_copy.num_low;
        end else begin
          res.code_class = rec.code;
        end
        res.voice_ok = (rec.voice_address != '0) &&
                       ((rec.voice_address[8:0] & scl_pkg::VOICE_ALIGN_MASK) == '0) &&
                       (rec.clip_bytes >= scl_pkg::VOICE_MIN_SIZE) &&
                       (rec.codec == scl_pkg::CODEC_COMPRESSED ||
                        rec.codec == scl_pkg::CODEC_WAV) &&
                       !enc_bad;
        // These are reported on every hit, even when the voice checks fail.
        res.voice_is_wav = (rec.codec == scl_pkg::CODEC_WAV);
        res.speech_encrypted = cfg_copy.encrypt_on && !enc_bad;
        res.voice_start = rec.voice_address + cfg_copy.base_address;
        return res;
      end
      if (key > rec.key) begin
        left = mid + 1;
      end else begin
        right = mid;
      end
    end
    return res;
  endfunction

  // A 16-bit value that lands on either end of the range a third of the time.
  function automatic logic [15:0] rand_code16();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // A random record whose voice fields pass the playback checks often enough
  // to matter, with each way of failing them showing up as well.
  function automatic scl_pkg::record_t rand_record();
    scl_pkg::record_t rec;
    rec.key = scl_pkg::KeyW'($urandom);
    rec.code = rand_code16();
    case ($urandom_range(0, 5))
      0, 1, 2: rec.voice_address = {23'($urandom_range(0, 32'h007F_FFFF)), 9'd0};
      3, 4:    rec.voice_address = $urandom;
      default: rec.voice_address = '0;
    endcase
    case ($urandom_range(0, 5))
      0:       rec.clip_bytes = $urandom;
      1:       rec.clip_bytes = scl_pkg::VOICE_MIN_SIZE;
      2:       rec.clip_bytes = scl_pkg::VOICE_MIN_SIZE - 1;
      3:       rec.clip_bytes = $urandom_range(0, 511);
      default: rec.clip_bytes = $urandom_range(512, 1_000_000);
    endcase
    case ($urandom_range(0, 5))
      0, 1:    rec.codec = scl_pkg::CODEC_COMPRESSED;
      2, 3:    rec.codec = scl_pkg::CODEC_WAV;
      default: rec.codec = scl_pkg::CodecW'($urandom);
    endcase
    return rec;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      error_count++;
      if (error_count <= 10) begin
        $display("Mismatch in %s at cycle %0d: expected %0h, got %0h", name,
                 cycle_count, exp_val, act_val);
      end
    end
  endtask

  // Every result beat is matched against the oldest outstanding expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10) begin
          $display("Unexpected result beat at cycle %0d", cycle_count);
        end
      end else begin
        oldest_expected = pending_results.pop_front();
        check_field("found", 32'(oldest_expected.found), 32'(found));
        check_field("hit_code", 32'(oldest_expected.hit_code), 32'(hit_code));
        check_field("code_class", 32'(oldest_expected.code_class), 32'(code_class));
        check_field("voice_ok", 32'(oldest_expected.voice_ok), 32'(voice_ok));
        check_field("voice_is_wav", 32'(oldest_expected.voice_is_wav),
                    32'(voice_is_wav));
        check_field("speech_encrypted", 32'(oldest_expected.speech_encrypted),
                    32'(speech_encrypted));
        check_field("voice_start", oldest_expected.voice_start, voice_start);
      end
    end
  end

  // Sends one input beat. The sender idles with probability tx_idle_pct per
  // cycle before presenting the beat. On return the beat has been accepted and
  // in_valid is still high, so a following beat can go out back to back.
  task automatic send_item(input logic act, input logic [scl_pkg::IndexW-1:0] idx,
                           input scl_pkg::record_t rec,
                           input logic [scl_pkg::KeyW-1:0] skey);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    entry_index <= idx;
    entry_key <= rec.key;
    entry_code <= rec.code;
    entry_voice_address <= rec.voice_address;
    entry_voice_size <= rec.clip_bytes;
    entry_codec <= rec.codec;
    search_key <= skey;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (act == scl_pkg::ACT_LOAD) begin
      record_copy[idx] = rec;
      if (!record_written[idx]) begin
        record_written[idx] = 1'b1;
        written_total++;
      end
      pending_results.push_back('0);
    end else begin
      pending_results.push_back(search_table(skey));
    end
  endtask

  // A load beat carries a random search key, which the block must ignore.
  task automatic send_load(input logic [scl_pkg::IndexW-1:0] idx,
                           input scl_pkg::record_t rec);
    send_item(scl_pkg::ACT_LOAD, idx, rec, scl_pkg::KeyW'($urandom));
  endtask

  // A lookup beat carries a random record and index, which must be ignored.
  task automatic send_lookup(input logic [scl_pkg::KeyW-1:0] key);
    send_item(scl_pkg::ACT_LOOKUP, scl_pkg::IndexW'($urandom), rand_record(), key);
  endtask

  // Stops sending and waits until every expected result has been seen, so
  // that the block is idle and registers may be written.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Writes one register. The valid line drops between writes because every
  // call first moves on to the next clock edge.
  task automatic write_register(input logic [scl_pkg::CfgIdxW-1:0] idx,
                                input logic [scl_pkg::CfgDataW-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      scl_pkg::REG_ENTRY_COUNT:  cfg_copy.entry_count = data[scl_pkg::CountW-1:0];
      scl_pkg::REG_ALPHA_LOW:    cfg_copy.alpha_low = data[scl_pkg::CodeW-1:0];
      scl_pkg::REG_ALPHA_HIGH:   cfg_copy.alpha_high = data[scl_pkg::CodeW-1:0];
      scl_pkg::REG_NUM_LOW:      cfg_copy.num_low = data[scl_pkg::CodeW-1:0];
      scl_pkg::REG_NUM_HIGH:     cfg_copy.num_high = data[scl_pkg::CodeW-1:0];
      scl_pkg::REG_ENCRYPT_ON:   cfg_copy.encrypt_on = data[0];
      scl_pkg::REG_ENCRYPT_KEY:  cfg_copy.encrypt_key = data[scl_pkg::EncKeyW-1:0];
      scl_pkg::REG_BASE_ADDRESS: cfg_copy.base_address = data[scl_pkg::AddrW-1:0];
      default: ;
    endcase
  endtask

  // Straight out of reset every register is zero, so a lookup searches an
  // empty table and must miss without touching the record memory. Loads with
  // all-zero and all-one fields exercise both ends of every field.
  task automatic test_after_reset();
    send_lookup(16'h0000);
    send_load(10'd0, '0);
    send_load(10'h3FF, '1);
    send_lookup(16'hFFFF);
  endtask

  // A small sorted table where each record exercises one class of code or
  // one way of failing the voice checks. The base address makes the start
  // address wrap past 32 bits on every record with a nonzero voice address.
  task automatic test_directed_table();
    int unsigned i;
    wait_for_results();
    write_register(scl_pkg::REG_ENTRY_COUNT, 32'd6);
    write_register(scl_pkg::REG_ALPHA_LOW, 32'h0100);
    write_register(scl_pkg::REG_ALPHA_HIGH, 32'h01FF);
    write_register(scl_pkg::REG_NUM_LOW, 32'h0200);
    write_register(scl_pkg::REG_NUM_HIGH, 32'h02FF);
    write_register(scl_pkg::REG_ENCRYPT_ON, 32'd0);
    write_register(scl_pkg::REG_ENCRYPT_KEY, 32'd0);
    write_register(scl_pkg::REG_BASE_ADDRESS, 32'hFFFF_FE00);
    // Alphabetic code, all checks pass.
    send_load(10'd0, {16'h0000, 16'h0150, 32'h0000_0200, 32'd512,
                      scl_pkg::CODEC_COMPRESSED});
    // Numeric code, voice address of zero, wav codec.
    send_load(10'd1, {16'h0010, 16'h0250, 32'h0000_0000, 32'd1024, scl_pkg::CODEC_WAV});
    // Code outside both ranges, voice address not on a 512-byte boundary.
    send_load(10'd2, {16'h0020, 16'h0300, 32'h0000_0201, 32'd4096,
                      scl_pkg::CODEC_COMPRESSED});
    // Voice size one byte short; start address wraps around.
    send_load(10'd3, {16'h0030, 16'hFFFF, 32'hFFFF_FE00, 32'd511, scl_pkg::CODEC_WAV});
    // Code on the low edge of the alphabetic range, unsupported codec.
    send_load(10'd4, {16'h0040, 16'h0100, 32'h0000_1000, 32'hFFFF_FFFF, 8'd1});
    // Highest key, code on the high edge of the numeric range, codec 255.
    send_load(10'd5, {16'hFFFF, 16'h02FF, 32'h0000_2000, 32'd600, 8'hFF});
    for (i = 0; i < 6; i++) begin
      send_lookup(record_copy[i].key);
    end
    // Misses between records and just below the top key.
    send_lookup(16'h0005);
    send_lookup(16'hFFFE);
    // Encryption with the largest valid key index, then with an invalid one,
    // which must also fail the voice checks.
    wait_for_results();
    write_register(scl_pkg::REG_ENCRYPT_ON, 32'd1);
    write_register(scl_pkg::REG_ENCRYPT_KEY, {24'd0, scl_pkg::ENC_KEY_MAX});
    send_lookup(16'h0000);
    wait_for_results();
    write_register(scl_pkg::REG_ENCRYPT_KEY, {24'd0, scl_pkg::ENC_KEY_MAX} + 32'd1);
    send_lookup(16'h0000);
  endtask

  // Breaks the ordering of the directed table. The probe sequence then
  // walks past both the misplaced key and a key it displaced, while a key
  // on the untouched path is still found.
  task automatic test_unsorted_table();
    send_load(10'd1, {16'h0050, 16'h0250, 32'h0000_0400, 32'd2048, scl_pkg::CODEC_WAV});
    send_lookup(16'h0050);
    send_lookup(16'h0010);
    send_lookup(16'h0030);
  endtask

  // Fills the whole memory with a strictly ascending table, one key in each
  // block of 64, from key zero to the top key. It is then searched with the
  // entry count at the memory depth, above it (clamped), and one below it.
  task automatic test_full_table();
    int unsigned      i;
    scl_pkg::record_t rec;
    wait_for_results();
    write_register(scl_pkg::REG_ENTRY_COUNT, TABLE_DEPTH);
    for (i = 0; i < TABLE_DEPTH; i++) begin
      rec = rand_record();
      if (i == 0) begin
        rec.key = 16'h0000;
      end else if (i == TABLE_DEPTH - 1) begin
        rec.key = 16'hFFFF;
      end else begin
        rec.key = scl_pkg::KeyW'(i * 64 + $urandom_range(0, 63));
      end
      send_load(scl_pkg::IndexW'(i), rec);
    end
    send_lookup(16'h0000);
    send_lookup(16'hFFFF);
    for (i = 0; i < 24; i++) begin
      send_lookup(record_copy[$urandom_range(0, TABLE_DEPTH - 1)].key);
    end
    send_lookup(record_copy[$urandom_range(0, TABLE_DEPTH - 2)].key + 16'd1);
    wait_for_results();
    write_register(scl_pkg::REG_ENTRY_COUNT, 32'h7FF);
    send_lookup(16'hFFFF);
    for (i = 0; i < 16; i++) begin
      send_lookup(record_copy[$urandom_range(0, TABLE_DEPTH - 1)].key);
    end
    // The top record now lies outside the searched range.
    wait_for_results();
    write_register(scl_pkg::REG_ENTRY_COUNT, TABLE_DEPTH - 1);
    send_lookup(16'hFFFF);
    send_lookup(record_copy[TABLE_DEPTH - 2].key);
  endtask

  // One round of random traffic: fresh register settings, usually a fresh
  // sorted table at the bottom of memory, then a mix of lookups that mostly
  // hit, lookups that mostly miss, loads that keep the order intact, and a
  // few loads that break it. The entry count never reaches past the records
  // written so far, so no lookup probes an unwritten entry.
  task automatic run_random_round(input int unsigned beats);
    int unsigned      i;
    int unsigned      pick;
    int unsigned      table_size;
    int unsigned      step_max;
    int unsigned      key;
    int unsigned      count;
    int unsigned      eff_count;
    int unsigned      idx;
    scl_pkg::record_t rec;
    wait_for_results();
    write_register(scl_pkg::REG_ALPHA_LOW, 32'(rand_code16()));
    write_register(scl_pkg::REG_ALPHA_HIGH, 32'(rand_code16()));
    write_register(scl_pkg::REG_NUM_LOW, 32'(rand_code16()));
    write_register(scl_pkg::REG_NUM_HIGH, 32'(rand_code16()));
    write_register(scl_pkg::REG_ENCRYPT_ON, $urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0: write_register(scl_pkg::REG_ENCRYPT_KEY, 32'd0);
      1: write_register(scl_pkg::REG_ENCRYPT_KEY, {24'd0, scl_pkg::ENC_KEY_MAX});
      2: write_register(scl_pkg::REG_ENCRYPT_KEY, {24'd0, scl_pkg::ENC_KEY_MAX} + 32'd1);
      3: write_register(scl_pkg::REG_ENCRYPT_KEY, 32'hFF);
      default: write_register(scl_pkg::REG_ENCRYPT_KEY, $urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 3))
      0: write_register(scl_pkg::REG_BASE_ADDRESS, 32'h0000_0000);
      1: write_register(scl_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFFF);
      2: write_register(scl_pkg::REG_BASE_ADDRESS,
                        {23'($urandom_range(0, 32'h007F_FFFF)), 9'd0});
      default: write_register(scl_pkg::REG_BASE_ADDRESS, $urandom);
    endcase
    if (written_total == TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
      // Search whatever now fills the memory, with a count near or above
      // the depth.
      count = $urandom_range(TABLE_DEPTH - 8, 11'h7FF);
      write_register(scl_pkg::REG_ENTRY_COUNT, count);
    end else begin
      table_size = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 48);
      count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, table_size) : table_size;
      write_register(scl_pkg::REG_ENTRY_COUNT, count);
      // Ascending keys spread over the whole key range; a zero step gives
      // the occasional duplicate key.
      step_max = 65535 / table_size;
      key = $urandom_range(0, step_max);
      for (i = 0; i < table_size; i++) begin
        if (i != 0) begin
          key = key + $urandom_range(0, step_max);
        end
        rec = rand_record();
        rec.key = scl_pkg::KeyW'(key);
        send_load(scl_pkg::IndexW'(i), rec);
      end
    end
    eff_count = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
    for (i = 0; i < beats; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 65 && eff_count > 0) begin
        send_lookup(record_copy[$urandom_range(0, eff_count - 1)].key);
      end else if (pick < 80) begin
        if (eff_count > 0 && $urandom_range(0, 1) == 0) begin
          send_lookup(record_copy[$urandom_range(0, eff_count - 1)].key + 16'd1);
        end else begin
          send_lookup(scl_pkg::KeyW'($urandom));
        end
      end else if (pick < 92) begin
        // Rewrite a record with its own key, so the order is kept.
        idx = (eff_count > 0) ? $urandom_range(0, eff_count - 1) : $urandom_range(0, 1023);
        rec = rand_record();
        rec.key = record_copy[idx].key;
        send_load(scl_pkg::IndexW'(idx), rec);
      end else begin
        send_load(scl_pkg::IndexW'($urandom_range(0, 1023)), rand_record());
      end
      // Now and then the sender holds off until the block has drained.
      if ($urandom_range(0, 49) == 0) begin
        wait_for_results();
      end
    end
  endtask

  task automatic test_random_traffic(input int unsigned beats);
    int unsigned target;
    target = beats_sent + beats;
    while (beats_sent < target) begin
      run_random_round($urandom_range(10, 40));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Slow receiver, mostly eager sender.
    tx_idle_pct = 9;
    rx_idle_pct = 66;
    test_after_reset();
    test_directed_table();
    test_unsorted_table();
    test_random_traffic(40);

    // Slow sender, mostly eager receiver.
    tx_idle_pct = 66;
    rx_idle_pct = 9;
    test_full_table();
    test_random_traffic(40);

    // Both sides at full rate.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(60);

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += pending_results.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
